@@ design/cartridge_gpio_serial_rtc_macros.svh @@
`ifndef CARTRIDGE_GPIO_SERIAL_RTC_MACROS_SVH
`define CARTRIDGE_GPIO_SERIAL_RTC_MACROS_SVH

// Both macros expect clk and rst_n in the scope where they are used.

// The property must hold at every clock edge outside reset.
`define CGSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define CGSR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/cgsr_pkg.sv @@
`timescale 1ns / 1ps

package cgsr_pkg;

  // GPIO register offsets.
  localparam logic [7:0] OFF_DATA      = 8'hc4;
  localparam logic [7:0] OFF_DIRECTION = 8'hc6;
  localparam logic [7:0] OFF_CONTROL   = 8'hc8;

  // Pin positions within the 4-bit GPIO port.
  localparam int PIN_SCK = 0;
  localparam int PIN_SIO = 1;
  localparam int PIN_CS  = 2;

  // Serial clock commands.
  localparam logic [7:0] CMD_IDLE         = 8'h00;
  localparam logic [7:0] CMD_RESET_A      = 8'h60;
  localparam logic [7:0] CMD_RESET_B      = 8'h61;
  localparam logic [7:0] CMD_WR_STATUS    = 8'h62;
  localparam logic [7:0] CMD_RD_STATUS    = 8'h63;
  localparam logic [7:0] CMD_WR_DATE_TIME = 8'h64;
  localparam logic [7:0] CMD_RD_DATE_TIME = 8'h65;
  localparam logic [7:0] CMD_WR_TIME      = 8'h66;
  localparam logic [7:0] CMD_RD_TIME      = 8'h67;

  // Payload bit counts of the write commands.
  localparam logic [5:0] LEN_STATUS    = 6'd8;
  localparam logic [5:0] LEN_DATE_TIME = 6'd56;
  localparam logic [5:0] LEN_TIME      = 6'd24;
  localparam logic [5:0] COUNT_MAX     = 6'd63;

  localparam logic [7:0] STATUS_RESET = 8'h40;

  typedef struct packed {
    logic        action;
    logic [7:0]  offset;
    logic [15:0] write_value;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } access_t;

  // Tens through a reciprocal multiply, exact for every 7-bit value.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  // Replies leave LSB first, so each byte is stored reversed.
  function automatic logic [7:0] bit_rev(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

endpackage

@@ design/cgsr_if.sv @@
`timescale 1ns / 1ps

interface cgsr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  offset;
  logic [15:0] write_value;
  logic [6:0]  year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source(output valid, action, offset, write_value, year, month, day,
                 weekday, hour, minute, second, input ready);
  modport sink(input valid, action, offset, write_value, year, month, day,
               weekday, hour, minute, second, output ready);
endinterface

interface cgsr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source(output valid, read_data, input ready);
  modport sink(input valid, read_data, output ready);
endinterface

interface cgsr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;

  modport source(output valid, status_byte, input ready);
  modport sink(input valid, status_byte, output ready);
endinterface

@@ design/cartridge_gpio_serial_rtc.sv @@
`timescale 1ns / 1ps
// An access reaches the result side through the input register and then the result register.
// Throughput: one access per cycle while results are taken; the only loop is the GPIO/serial
// state update.
// A stalled result lets one more access into the input register, then input stops.
// Reset (synchronous, active low) clears all GPIO and serial state and sets the status byte to 0x40.
`include "cartridge_gpio_serial_rtc_macros.svh"

module cartridge_gpio_serial_rtc (
  input  logic        clk,
  input  logic        rst_n,
  cgsr_in_if.sink     in_ch,
  cgsr_out_if.source  out_ch,
  cgsr_cfg_if.sink    cfg_ch
);
  import cgsr_pkg::*;

  logic        stage_valid_r, stage_valid_nxt;
  access_t     stage_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] read_data_r, read_data_nxt;
  logic        in_xfer, fire;

  logic [7:0]  status_byte_r;
  logic [3:0]  pin_data_r, pin_data_nxt;
  logic [3:0]  pin_direction_r, pin_direction_nxt;
  logic        reads_on_r, reads_on_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [7:0]  write_shift_r, write_shift_nxt;
  logic [5:0]  write_count_r, write_count_nxt;
  logic [55:0] reply_shift_r, reply_shift_nxt;
  logic [5:0]  reply_count_r, reply_count_nxt;

  assign fire         = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !stage_valid_r || fire;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.read_data = read_data_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_xfer) begin
      stage_valid_nxt = 1'b1;
    end else if (fire) begin
      stage_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin : access_logic
    logic [3:0] pd;
    logic       sbit;
    logic [7:0] ws;
    logic [5:0] wc;
    logic [5:0] need;
    logic [5:0] rc_dec;

    pin_data_nxt      = pin_data_r;
    pin_direction_nxt = pin_direction_r;
    reads_on_nxt      = reads_on_r;
    command_nxt       = command_r;
    write_shift_nxt   = write_shift_r;
    write_count_nxt   = write_count_r;
    reply_shift_nxt   = reply_shift_r;
    reply_count_nxt   = reply_count_r;
    read_data_nxt     = read_data_r;
    pd     = stage_r.write_value[3:0];
    sbit   = pd[PIN_SIO];
    ws     = {write_shift_r[6:0], sbit};
    wc     = (write_count_r == COUNT_MAX) ? COUNT_MAX : write_count_r + 6'd1;
    rc_dec = reply_count_r - 6'd1;
    need   = '0;

    if (fire) begin
      read_data_nxt = '0;
      if (!stage_r.action) begin
        if (reads_on_r) begin
          case (stage_r.offset)
            OFF_DATA:      read_data_nxt = {12'b0, pin_data_r};
            OFF_DIRECTION: read_data_nxt = {12'b0, pin_direction_r};
            OFF_CONTROL:   read_data_nxt = {15'b0, reads_on_r};
            default:       read_data_nxt = '0;
          endcase
        end
      end else begin
        case (stage_r.offset)
          OFF_DATA: begin
            pin_data_nxt = pd;
            // A serial bit moves on a rising clock with chip select high.
            if (pd[PIN_CS] && pd[PIN_SCK] && !pin_data_r[PIN_SCK]) begin
              if (pin_direction_r[PIN_SIO]) begin
                write_shift_nxt = ws;
                write_count_nxt = wc;
                if (command_r == CMD_IDLE) begin
                  if (wc >= 6'd8) begin
                    write_shift_nxt = '0;
                    write_count_nxt = '0;
                    reply_shift_nxt = '0;
                    reply_count_nxt = '0;
                    command_nxt     = CMD_IDLE;
                    case (ws)
                      CMD_RESET_A, CMD_RESET_B: command_nxt = CMD_IDLE;
                      CMD_RD_STATUS: begin
                        reply_shift_nxt = {48'b0, bit_rev(status_byte_r)};
                        reply_count_nxt = 6'd8;
                      end
                      CMD_RD_DATE_TIME: begin
                        reply_shift_nxt = {bit_rev(to_bcd(stage_r.year)),
                                           bit_rev(to_bcd({3'b0, stage_r.month})),
                                           bit_rev(to_bcd({2'b0, stage_r.day})),
                                           bit_rev(to_bcd({4'b0, stage_r.weekday})),
                                           bit_rev(to_bcd({2'b0, stage_r.hour})),
                                           bit_rev(to_bcd({1'b0, stage_r.minute})),
                                           bit_rev(to_bcd({1'b0, stage_r.second}))};
                        reply_count_nxt = 6'd56;
                      end
                      CMD_RD_TIME: begin
                        reply_shift_nxt = {32'b0,
                                           bit_rev(to_bcd({2'b0, stage_r.hour})),
                                           bit_rev(to_bcd({1'b0, stage_r.minute})),
                                           bit_rev(to_bcd({1'b0, stage_r.second}))};
                        reply_count_nxt = 6'd24;
                      end
                      // Write commands wait for payload; an unknown one stays forever.
                      default: command_nxt = ws;
                    endcase
                  end
                end else begin
                  case (command_r)
                    CMD_WR_STATUS:    need = LEN_STATUS;
                    CMD_WR_DATE_TIME: need = LEN_DATE_TIME;
                    CMD_WR_TIME:      need = LEN_TIME;
                    default:          need = '0;
                  endcase
                  if (need != '0 && wc >= need) begin
                    command_nxt     = CMD_IDLE;
                    write_shift_nxt = '0;
                    write_count_nxt = '0;
                  end
                end
              end else if (reply_count_r != '0) begin
                reply_count_nxt       = rc_dec;
                pin_data_nxt[PIN_SIO] = reply_shift_r[rc_dec];
              end else begin
                pin_data_nxt[PIN_SIO] = 1'b0;
              end
            end
          end
          OFF_DIRECTION: pin_direction_nxt = stage_r.write_value[3:0];
          OFF_CONTROL:   reads_on_nxt = stage_r.write_value[0];
          default:       read_data_nxt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r   <= 1'b0;
      out_valid_r     <= 1'b0;
      status_byte_r   <= STATUS_RESET;
      pin_data_r      <= '0;
      pin_direction_r <= '0;
      reads_on_r      <= 1'b0;
      command_r       <= CMD_IDLE;
      write_shift_r   <= '0;
      write_count_r   <= '0;
      reply_shift_r   <= '0;
      reply_count_r   <= '0;
    end else begin
      stage_valid_r   <= stage_valid_nxt;
      out_valid_r     <= out_valid_nxt;
      pin_data_r      <= pin_data_nxt;
      pin_direction_r <= pin_direction_nxt;
      reads_on_r      <= reads_on_nxt;
      command_r       <= command_nxt;
      write_shift_r   <= write_shift_nxt;
      write_count_r   <= write_count_nxt;
      reply_shift_r   <= reply_shift_nxt;
      reply_count_r   <= reply_count_nxt;
      if (cfg_ch.valid) begin
        status_byte_r <= cfg_ch.status_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_r <= '{action: in_ch.action, offset: in_ch.offset,
                   write_value: in_ch.write_value, year: in_ch.year,
                   month: in_ch.month, day: in_ch.day, weekday: in_ch.weekday,
                   hour: in_ch.hour, minute: in_ch.minute, second: in_ch.second};
    end
    read_data_r <= read_data_nxt;
  end

  // Every accepted access is held in the input register on the next cycle.
  `CGSR_ASSERT(a_in_captured, in_xfer |=> stage_valid_r, "accepted access was lost")

  // A reply never holds more than seven bytes.
  `CGSR_ASSERT_NEVER(a_reply_bound, reply_count_r > 6'd56, "reply count overflow")

  // Commands that finish at decode never remain pending.
  `CGSR_ASSERT_NEVER(a_no_stuck_read,
      command_r == CMD_RD_STATUS || command_r == CMD_RD_DATE_TIME ||
      command_r == CMD_RD_TIME || command_r == CMD_RESET_A || command_r == CMD_RESET_B,
      "completed command left pending")

  // While idle the collector never holds a full command byte.
  `CGSR_ASSERT(a_idle_count, (command_r == CMD_IDLE) |-> (write_count_r < 6'd8),
      "idle collector holds a full byte")

endmodule

@@ tb/sv/cgsr_checker.sv @@
`timescale 1ns / 1ps

module cgsr_checker (
  input  logic clk,
  input  logic rst_n,
  cgsr_in_if   in_ch,
  cgsr_out_if  out_ch,
  cgsr_cfg_if  cfg_ch,
  output int   fail_count,
  output int   outstanding
);
  import cgsr_pkg::*;

  // Mirror of the GPIO port and of the serial clock behind it.
  logic [3:0]  gp_data;
  logic [3:0]  gp_dir;
  logic        rd_en;
  logic [7:0]  rtc_cmd;
  logic [55:0] col_bits;
  logic [5:0]  col_count;
  logic [55:0] reply_bits;
  logic [5:0]  reply_left;
  logic [7:0]  status_copy;

  logic [15:0] read_data_due[$];
  int          errors;

  function automatic logic [7:0] bcd_of(input int unsigned v);
    int unsigned x;
    x = v & 32'hff;
    return 8'(((x / 10) << 4) | (x % 10));
  endfunction

  // Reply bytes go out LSB first, so each one is stored bit-reversed.
  function automatic void queue_reply(input logic [7:0] b);
    logic [7:0] rev;
    for (int i = 0; i < 8; i++) begin
      rev[7 - i] = b[i];
    end
    reply_bits = {reply_bits[47:0], rev};
    if (reply_left <= 6'd55) begin
      reply_left = reply_left + 6'd8;
    end else begin
      reply_left = COUNT_MAX;
    end
  endfunction

  function automatic logic next_reply_bit();
    if (reply_left == 6'd0) begin
      return 1'b0;
    end
    reply_left = reply_left - 6'd1;
    if (reply_left > 6'd55) begin
      return 1'b0;
    end
    return reply_bits[reply_left];
  endfunction

  function automatic void shift_in(input logic b, input access_t a);
    logic [5:0] need;
    col_bits = {col_bits[54:0], b};
    if (col_count != COUNT_MAX) begin
      col_count = col_count + 6'd1;
    end
    if (rtc_cmd == CMD_IDLE) begin
      if (col_count < 6'd8) begin
        return;
      end
      rtc_cmd    = col_bits[7:0];
      reply_bits = '0;
      reply_left = '0;
      col_bits   = '0;
      col_count  = '0;
      case (rtc_cmd)
        CMD_RESET_A, CMD_RESET_B: begin
          rtc_cmd = CMD_IDLE;
        end
        CMD_RD_STATUS: begin
          queue_reply(status_copy);
          rtc_cmd = CMD_IDLE;
        end
        CMD_RD_DATE_TIME: begin
          queue_reply(bcd_of(a.year));
          queue_reply(bcd_of(a.month));
          queue_reply(bcd_of(a.day));
          queue_reply(bcd_of(a.weekday));
          queue_reply(bcd_of(a.hour));
          queue_reply(bcd_of(a.minute));
          queue_reply(bcd_of(a.second));
          rtc_cmd = CMD_IDLE;
        end
        CMD_RD_TIME: begin
          queue_reply(bcd_of(a.hour));
          queue_reply(bcd_of(a.minute));
          queue_reply(bcd_of(a.second));
          rtc_cmd = CMD_IDLE;
        end
        // Write commands wait for their payload; any other byte but the idle one locks up here.
        default: ;
      endcase
    end else begin
      case (rtc_cmd)
        CMD_WR_STATUS:    need = LEN_STATUS;
        CMD_WR_DATE_TIME: need = LEN_DATE_TIME;
        CMD_WR_TIME:      need = LEN_TIME;
        default:          need = 6'd0;
      endcase
      if (need != 6'd0 && col_count >= need) begin
        rtc_cmd   = CMD_IDLE;
        col_bits  = '0;
        col_count = '0;
      end
    end
  endfunction

  function automatic logic [15:0] apply_access(input access_t a);
    logic [15:0] rd;
    logic [3:0]  prev;
    rd = '0;
    if (!a.action) begin
      if (rd_en) begin
        case (a.offset)
          OFF_DATA:      rd = {12'b0, gp_data};
          OFF_DIRECTION: rd = {12'b0, gp_dir};
          OFF_CONTROL:   rd = {15'b0, rd_en};
          default:       rd = '0;
        endcase
      end
    end else begin
      case (a.offset)
        OFF_DATA: begin
          prev    = gp_data;
          gp_data = a.write_value[3:0];
          if (gp_data[PIN_CS] && gp_data[PIN_SCK] && !prev[PIN_SCK]) begin
            if (gp_dir[PIN_SIO]) begin
              shift_in(gp_data[PIN_SIO], a);
            end else begin
              gp_data[PIN_SIO] = next_reply_bit();
            end
          end
        end
        OFF_DIRECTION: gp_dir = a.write_value[3:0];
        OFF_CONTROL:   rd_en = a.write_value[0];
        default: ;
      endcase
    end
    return rd;
  endfunction

  always @(posedge clk) begin : watch
    access_t     smp;
    logic [15:0] want;
    if (!rst_n) begin
      gp_data     = '0;
      gp_dir      = '0;
      rd_en       = 1'b0;
      rtc_cmd     = CMD_IDLE;
      col_bits    = '0;
      col_count   = '0;
      reply_bits  = '0;
      reply_left  = '0;
      status_copy = STATUS_RESET;
      errors      = 0;
      read_data_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        status_copy = cfg_ch.status_byte;
      end
      // A result leaves only after its access has passed the input and result registers, so retire first.
      if (out_ch.valid && out_ch.ready) begin
        if (read_data_due.size() == 0) begin
          $error("read_data: expected none, actual %h", out_ch.read_data);
          errors++;
        end else begin
          want = read_data_due.pop_front();
          if (want !== out_ch.read_data) begin
            $error("read_data: expected %h, actual %h", want, out_ch.read_data);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        smp.action      = in_ch.action;
        smp.offset      = in_ch.offset;
        smp.write_value = in_ch.write_value;
        smp.year        = in_ch.year;
        smp.month       = in_ch.month;
        smp.day         = in_ch.day;
        smp.weekday     = in_ch.weekday;
        smp.hour        = in_ch.hour;
        smp.minute      = in_ch.minute;
        smp.second      = in_ch.second;
        read_data_due.push_back(apply_access(smp));
      end
    end
    fail_count  <= errors;
    outstanding <= read_data_due.size();
  end

endmodule

@@ tb/sv/tb_cartridge_gpio_serial_rtc.sv @@
`timescale 1ns / 1ps

module tb_cartridge_gpio_serial_rtc;
  import cgsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 250;
  localparam int PHASES = 6;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int unsigned cycles = 0;

  cgsr_in_if  in_ch();
  cgsr_out_if out_ch();
  cgsr_cfg_if cfg_ch();

  cartridge_gpio_serial_rtc u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cgsr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stimulus steering only: where the serial collector stands, so that random
  // traffic never completes a command byte by accident.
  logic       dir_sio_out;
  logic       sck_last;
  int         payload_left;
  int         sent_items;
  int         send_calm;
  logic [1:0] time_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic access_t make_access(input logic act, input logic [7:0] off,
                                          input logic [15:0] val);
    access_t a;
    a.action      = act;
    a.offset      = off;
    a.write_value = val;
    case (time_mode)
      2'd0: begin
        a.year    = 7'($urandom);
        a.month   = 4'($urandom);
        a.day     = 5'($urandom);
        a.weekday = 3'($urandom);
        a.hour    = 5'($urandom);
        a.minute  = 6'($urandom);
        a.second  = 6'($urandom);
      end
      2'd1: begin
        a.year    = '1;
        a.month   = '1;
        a.day     = '1;
        a.weekday = '1;
        a.hour    = '1;
        a.minute  = '1;
        a.second  = '1;
      end
      2'd2: begin
        a.year    = '0;
        a.month   = '0;
        a.day     = '0;
        a.weekday = '0;
        a.hour    = '0;
        a.minute  = '0;
        a.second  = '0;
      end
      default: begin
        a.year    = 7'($urandom_range(0, 99));
        a.month   = 4'($urandom_range(1, 12));
        a.day     = 5'($urandom_range(1, 31));
        a.weekday = 3'($urandom_range(0, 6));
        a.hour    = 5'($urandom_range(0, 23));
        a.minute  = 6'($urandom_range(0, 59));
        a.second  = 6'($urandom_range(0, 59));
      end
    endcase
    return a;
  endfunction

  task automatic put(input access_t a);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 60) == 0) send_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.action      <= a.action;
    in_ch.offset      <= a.offset;
    in_ch.write_value <= a.write_value;
    in_ch.year        <= a.year;
    in_ch.month       <= a.month;
    in_ch.day         <= a.day;
    in_ch.weekday     <= a.weekday;
    in_ch.hour        <= a.hour;
    in_ch.minute      <= a.minute;
    in_ch.second      <= a.second;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (a.action && a.offset == OFF_DATA) begin
      if (dir_sio_out && a.write_value[PIN_CS] && a.write_value[PIN_SCK] && !sck_last &&
          payload_left > 0) begin
        payload_left--;
      end
      sck_last = a.write_value[PIN_SCK];
    end
    if (a.action && a.offset == OFF_DIRECTION) dir_sio_out = a.write_value[PIN_SIO];
    if (!a.action || a.offset inside {OFF_DATA, OFF_DIRECTION, OFF_CONTROL}) sent_items++;
  endtask

  task automatic wr(input logic [7:0] off, input logic [15:0] val);
    put(make_access(1'b1, off, val));
  endtask

  task automatic rd(input logic [7:0] off);
    put(make_access(1'b0, off, 16'($urandom)));
  endtask

  // Wait until every access sent so far has produced its result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_status(input logic [7:0] v);
    cfg_ch.status_byte <= v;
    cfg_ch.valid       <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_direction(input logic sio_out);
    logic [15:0] v;
    v = 16'($urandom);
    v[PIN_SCK] = 1'b1;
    v[PIN_CS]  = 1'b1;
    v[PIN_SIO] = sio_out;
    wr(OFF_DIRECTION, v);
  endtask

  task automatic clock_bit_out(input logic b);
    logic [15:0] v;
    v = 16'($urandom);
    v[PIN_CS]  = 1'b1;
    v[PIN_SIO] = b;
    v[PIN_SCK] = 1'b0;
    wr(OFF_DATA, v);
    v[PIN_SCK] = 1'b1;
    wr(OFF_DATA, v);
  endtask

  task automatic clock_bit_in();
    logic [15:0] v;
    v = 16'($urandom);
    v[PIN_CS]  = 1'b1;
    v[PIN_SCK] = 1'b0;
    wr(OFF_DATA, v);
    v[PIN_SCK] = 1'b1;
    wr(OFF_DATA, v);
    if ($urandom_range(0, 7) == 0) rd(8'($urandom));
    else rd(OFF_DATA);
  endtask

  task automatic send_command(input logic [7:0] cmd);
    logic [15:0] v;
    set_direction(1'b1);
    // A payload cut short earlier is finished first so the byte lines up.
    while (payload_left > 0) clock_bit_out(1'($urandom));
    v = 16'($urandom);
    v[PIN_CS]  = 1'b0;
    v[PIN_SCK] = 1'b0;
    wr(OFF_DATA, v);
    for (int i = 7; i >= 0; i--) begin
      clock_bit_out(cmd[i]);
    end
    case (cmd)
      CMD_WR_STATUS:    payload_left = LEN_STATUS;
      CMD_WR_DATE_TIME: payload_left = LEN_DATE_TIME;
      CMD_WR_TIME:      payload_left = LEN_TIME;
      default:          payload_left = 0;
    endcase
  endtask

  function automatic logic [7:0] cmd_by_index(input int k);
    case (k)
      0:       return CMD_RESET_A;
      1:       return CMD_RESET_B;
      2:       return CMD_WR_STATUS;
      3:       return CMD_RD_STATUS;
      4:       return CMD_WR_DATE_TIME;
      5:       return CMD_RD_DATE_TIME;
      6:       return CMD_WR_TIME;
      7:       return CMD_RD_TIME;
      8:       return CMD_IDLE;
      9:       return CMD_RD_DATE_TIME;
      10:      return CMD_RD_TIME;
      default: return CMD_RD_STATUS;
    endcase
  endfunction

  task automatic run_sequence(input logic [7:0] cmd);
    int nbits;
    int reply_len;
    if ($urandom_range(0, 9) == 0) begin
      wr(OFF_CONTROL, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
    end
    send_command(cmd);
    case (cmd)
      CMD_WR_STATUS, CMD_WR_DATE_TIME, CMD_WR_TIME: begin
        nbits = payload_left;
        if ($urandom_range(0, 4) == 0) nbits = $urandom_range(0, nbits - 1);
        repeat (nbits) clock_bit_out(1'($urandom));
      end
      CMD_RD_STATUS, CMD_RD_DATE_TIME, CMD_RD_TIME: begin
        if (cmd == CMD_RD_STATUS) reply_len = 8;
        else if (cmd == CMD_RD_DATE_TIME) reply_len = 56;
        else reply_len = 24;
        case ($urandom_range(0, 5))
          0:       nbits = $urandom_range(0, reply_len - 1);
          1:       nbits = reply_len + $urandom_range(1, 12);
          default: nbits = reply_len;
        endcase
        set_direction(1'b0);
        repeat (nbits) clock_bit_in();
      end
      default: ;
    endcase
  endtask

  task automatic noise(input int n);
    access_t     a;
    logic [7:0]  off;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0:       off = OFF_DIRECTION;
        1:       off = OFF_CONTROL;
        2:       off = 8'($urandom);
        default: off = OFF_DATA;
      endcase
      a = make_access(1'($urandom), off, 16'($urandom));
      if (a.action && payload_left == 0) begin
        if (off == OFF_DIRECTION) a.write_value[PIN_SIO] = 1'b0;
        if (off == OFF_DATA && dir_sio_out && a.write_value[PIN_CS] &&
            a.write_value[PIN_SCK] && !sck_last) begin
          a.write_value[PIN_CS] = 1'b0;
        end
      end
      put(a);
    end
  endtask

  initial begin : result_sink
    int stall;
    int calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
        if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 100);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : stimulus
    int          base;
    logic [7:0]  stuck_cmd;
    dir_sio_out  = 1'b0;
    sck_last     = 1'b0;
    payload_left = 0;
    sent_items   = 0;
    send_calm    = 0;
    time_mode    = 2'd3;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= 1'b0;
    in_ch.offset       <= '0;
    in_ch.write_value  <= '0;
    in_ch.year         <= '0;
    in_ch.month        <= '0;
    in_ch.day          <= '0;
    in_ch.weekday      <= '0;
    in_ch.hour         <= '0;
    in_ch.minute       <= '0;
    in_ch.second       <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.status_byte <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Register access corners; reads stay zero until read-enable is set.
    rd(OFF_DATA);
    rd(OFF_CONTROL);
    wr(OFF_CONTROL, 16'hffff);
    rd(OFF_CONTROL);
    wr(OFF_DIRECTION, 16'hffff);
    rd(OFF_DIRECTION);
    wr(OFF_DIRECTION, 16'h0000);
    rd(OFF_DIRECTION);
    // Data line is an input here, so this clock edge asks for an empty reply.
    wr(OFF_DATA, 16'hffff);
    rd(OFF_DATA);
    wr(OFF_DATA, 16'h0000);
    rd(OFF_DATA);
    rd(8'h00);
    rd(8'hff);
    wr(8'hff, 16'hffff);
    wr(8'h00, 16'h0000);
    wr(OFF_CONTROL, 16'h0000);
    rd(OFF_DIRECTION);
    wr(OFF_CONTROL, 16'h0001);
    rd(OFF_CONTROL);

    // Every command once with the largest time fields and once with zeros,
    // starting from the status byte left by reset.
    for (int m = 1; m <= 2; m++) begin
      time_mode = 2'(m);
      for (int k = 0; k <= 8; k++) begin
        run_sequence(cmd_by_index(k));
      end
    end

    base = sent_items;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) set_status(8'h00);
      else if (p == 1) set_status(8'hff);
      else set_status(8'($urandom));
      while (sent_items < base + (p + 1) * RANDOM_ITEMS / PHASES) begin
        time_mode = 2'($urandom);
        if ($urandom_range(0, 9) < 7) run_sequence(cmd_by_index($urandom_range(0, 11)));
        else noise($urandom_range(1, 12));
      end
    end

    // An unknown command locks the serial side for good, so it comes last;
    // enough bits follow to saturate the bit counter.
    do stuck_cmd = 8'($urandom);
    while (stuck_cmd == CMD_IDLE || (stuck_cmd >= CMD_RESET_A && stuck_cmd <= CMD_RD_TIME));
    time_mode = 2'($urandom);
    send_command(stuck_cmd);
    repeat (70) clock_bit_out(1'($urandom));
    rd(OFF_DATA);
    run_sequence(CMD_RD_DATE_TIME);
    noise(20);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
